@@ src/bdq_pkg.sv @@
// Shared types and constants for the bounded deque with erase.
// Used by bdq_ctrl, bdq_dp and bounded_deque_with_erase_core; depends on nothing.
package bdq_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned ENTRY_W = 5;

	// Request codes carried in req_type.
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_ERASE      = 3'd4;

	// Result status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STATUS_FULL      = 2'd3;

	typedef logic [ENTRY_W-1:0] entry_count_t;

	typedef struct packed {
		logic [2:0]                req_type;
		logic signed [VALUE_W-1:0] operand_value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] result_value;
		logic [1:0]                status;
		entry_count_t              entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POP,
		ST_SEARCH,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_PUSH_FRONT,
		DP_PUSH_BACK,
		DP_READ_FRONT,
		DP_READ_BACK,
		DP_POP_COMMIT,
		DP_FAIL,
		DP_NOP_RESULT,
		DP_SCAN_START,
		DP_SCAN_NEXT,
		DP_SHIFT_START,
		DP_SHIFT_STEP,
		DP_SHIFT_LAST,
		DP_ERASE_END
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] fail_status;
		logic       load_req;
		logic       load_rsp;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       empty;
		logic       full;
		logic       match;
		logic       scan_end;
		logic       shift_end;
	} dp_stat_t;

endpackage

@@ src/bdq_ctrl.sv @@
// Controller state machine for the bounded deque with erase.
// Depends on bdq_pkg; drives bdq_dp through dp_cmd_t and reads dp_stat_t.
module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  bdq_pkg::dp_stat_t stat,
	output bdq_pkg::dp_cmd_t  cmd
);

	bdq_pkg::state_t state_q, state_d;
	logic            rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdq_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		cmd.op          = bdq_pkg::DP_NONE;
		cmd.fail_status = bdq_pkg::STATUS_OK;
		cmd.load_req    = 1'b0;
		cmd.load_rsp    = 1'b0;
		req_stall       = 1'b1;

		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = bdq_pkg::ST_DECODE;
				end
			end
			bdq_pkg::ST_DECODE: begin
				state_d = bdq_pkg::ST_DONE;
				unique case (stat.req_type)
					bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK: begin
						if (stat.full) begin
							cmd.op          = bdq_pkg::DP_FAIL;
							cmd.fail_status = bdq_pkg::STATUS_FULL;
						end else if (stat.req_type == bdq_pkg::REQ_PUSH_FRONT) begin
							cmd.op = bdq_pkg::DP_PUSH_FRONT;
						end else begin
							cmd.op = bdq_pkg::DP_PUSH_BACK;
						end
					end
					bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK: begin
						if (stat.empty) begin
							cmd.op          = bdq_pkg::DP_FAIL;
							cmd.fail_status = bdq_pkg::STATUS_EMPTY;
						end else begin
							cmd.op  = (stat.req_type == bdq_pkg::REQ_POP_FRONT) ?
								bdq_pkg::DP_READ_FRONT : bdq_pkg::DP_READ_BACK;
							state_d = bdq_pkg::ST_POP;
						end
					end
					bdq_pkg::REQ_ERASE: begin
						if (stat.empty) begin
							cmd.op          = bdq_pkg::DP_FAIL;
							cmd.fail_status = bdq_pkg::STATUS_EMPTY;
						end else begin
							cmd.op  = bdq_pkg::DP_SCAN_START;
							state_d = bdq_pkg::ST_SEARCH;
						end
					end
					default: begin
						cmd.op = bdq_pkg::DP_NOP_RESULT;
					end
				endcase
			end
			bdq_pkg::ST_POP: begin
				cmd.op  = bdq_pkg::DP_POP_COMMIT;
				state_d = bdq_pkg::ST_DONE;
			end
			bdq_pkg::ST_SEARCH: begin
				priority if (stat.match && stat.scan_end) begin
					cmd.op  = bdq_pkg::DP_ERASE_END;
					state_d = bdq_pkg::ST_DONE;
				end else if (stat.match) begin
					cmd.op  = bdq_pkg::DP_SHIFT_START;
					state_d = bdq_pkg::ST_SHIFT;
				end else if (stat.scan_end) begin
					cmd.op          = bdq_pkg::DP_FAIL;
					cmd.fail_status = bdq_pkg::STATUS_NOT_FOUND;
					state_d         = bdq_pkg::ST_DONE;
				end else begin
					cmd.op = bdq_pkg::DP_SCAN_NEXT;
				end
			end
			bdq_pkg::ST_SHIFT: begin
				if (stat.shift_end) begin
					cmd.op  = bdq_pkg::DP_SHIFT_LAST;
					state_d = bdq_pkg::ST_DONE;
				end else begin
					cmd.op = bdq_pkg::DP_SHIFT_STEP;
				end
			end
			bdq_pkg::ST_DONE: begin
				// hold the result until the output register is free
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_rsp = 1'b1;
					state_d      = bdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bdq_pkg::ST_IDLE;
			end
		endcase

		rsp_valid_d = cmd.load_rsp | (rsp_valid_q & rsp_stall);
	end

	assign rsp_valid = rsp_valid_q;

	a_accept_to_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdq_pkg::ST_IDLE && req_valid) |=> state_q == bdq_pkg::ST_DECODE)
		else $error("accepted request did not move to decode");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == bdq_pkg::ST_DONE)
		else $error("response raised outside of done state");

	a_busy_no_new_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdq_pkg::ST_SEARCH || state_q == bdq_pkg::ST_SHIFT) |-> !cmd.load_rsp)
		else $error("response loaded while erase still running");

endmodule

@@ src/bdq_dp.sv @@
// Datapath for the bounded deque with erase: word store, front index, count, result.
// Depends on bdq_pkg; controlled by bdq_ctrl through dp_cmd_t.
module bdq_dp #(
	parameter int unsigned DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bdq_pkg::req_t     req,
	input  bdq_pkg::dp_cmd_t  cmd,
	output bdq_pkg::dp_stat_t stat,
	output bdq_pkg::rsp_t     rsp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = AW + 1;
	localparam int unsigned VW = bdq_pkg::VALUE_W;

	logic [VW-1:0] mem [DEPTH];

	logic [AW-1:0]        front_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic [2:0]           req_type_q;
	logic signed [VW-1:0] val_q;
	logic [VW-1:0]        rdata_q;
	logic signed [VW-1:0] res_value_q;
	logic [1:0]           res_status_q;
	bdq_pkg::rsp_t        rsp_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [VW-1:0] wdata;
	logic [AW-1:0] front_dec;
	logic [CW-1:0] idx_inc;

	// Physical slot of a logical position, wrapping around the store.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
		input logic [CW-1:0] pos);
		logic [SW-1:0] s;
		s = SW'(front) + SW'(pos);
		if (s >= SW'(DEPTH))
			s = s - SW'(DEPTH);
		return s[AW-1:0];
	endfunction

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign idx_inc   = idx_q + 1'b1;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = front_q;
		raddr = front_q;
		wdata = val_q;
		unique case (cmd.op)
			bdq_pkg::DP_PUSH_FRONT: begin
				we    = 1'b1;
				waddr = front_dec;
			end
			bdq_pkg::DP_PUSH_BACK: begin
				we    = 1'b1;
				waddr = slot_of(front_q, count_q);
			end
			bdq_pkg::DP_READ_FRONT, bdq_pkg::DP_SCAN_START: begin
				re = 1'b1;
			end
			bdq_pkg::DP_READ_BACK: begin
				re    = 1'b1;
				raddr = slot_of(front_q, count_q - 1'b1);
			end
			bdq_pkg::DP_SCAN_NEXT, bdq_pkg::DP_SHIFT_START: begin
				re    = 1'b1;
				raddr = slot_of(front_q, idx_q);
			end
			bdq_pkg::DP_SHIFT_STEP: begin
				// move the word at idx one place forward, fetch the next one
				we    = 1'b1;
				waddr = slot_of(front_q, idx_q - 1'b1);
				wdata = rdata_q;
				re    = 1'b1;
				raddr = slot_of(front_q, idx_inc);
			end
			bdq_pkg::DP_SHIFT_LAST: begin
				we    = 1'b1;
				waddr = slot_of(front_q, idx_q - 1'b1);
				wdata = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else begin
			unique case (cmd.op)
				bdq_pkg::DP_PUSH_FRONT: begin
					front_q <= front_dec;
					count_q <= count_q + 1'b1;
				end
				bdq_pkg::DP_PUSH_BACK: begin
					count_q <= count_q + 1'b1;
				end
				bdq_pkg::DP_POP_COMMIT: begin
					if (req_type_q == bdq_pkg::REQ_POP_FRONT)
						front_q <= slot_of(front_q, CW'(1));
					count_q <= count_q - 1'b1;
				end
				bdq_pkg::DP_SHIFT_LAST, bdq_pkg::DP_ERASE_END: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q <= req.req_type;
			val_q      <= req.operand_value;
		end
		unique case (cmd.op)
			bdq_pkg::DP_PUSH_FRONT, bdq_pkg::DP_PUSH_BACK, bdq_pkg::DP_SHIFT_LAST,
			bdq_pkg::DP_ERASE_END: begin
				res_value_q  <= val_q;
				res_status_q <= bdq_pkg::STATUS_OK;
			end
			bdq_pkg::DP_POP_COMMIT: begin
				res_value_q  <= rdata_q;
				res_status_q <= bdq_pkg::STATUS_OK;
			end
			bdq_pkg::DP_FAIL: begin
				res_value_q  <= '1;
				res_status_q <= cmd.fail_status;
			end
			bdq_pkg::DP_NOP_RESULT: begin
				res_value_q  <= '0;
				res_status_q <= bdq_pkg::STATUS_OK;
			end
			bdq_pkg::DP_SCAN_START: begin
				idx_q <= CW'(1);
			end
			bdq_pkg::DP_SCAN_NEXT, bdq_pkg::DP_SHIFT_STEP: begin
				idx_q <= idx_inc;
			end
			default: begin
			end
		endcase
		if (cmd.load_rsp) begin
			rsp_q.result_value <= res_value_q;
			rsp_q.status       <= res_status_q;
			rsp_q.entry_count  <= bdq_pkg::entry_count_t'(count_q);
		end
	end

	assign stat.req_type  = req_type_q;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CW'(DEPTH));
	assign stat.match     = (rdata_q == val_q);
	assign stat.scan_end  = (idx_q == count_q);
	assign stat.shift_end = (idx_inc == count_q);
	assign rsp            = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stored count exceeds depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bdq_pkg::DP_SCAN_NEXT || cmd.op == bdq_pkg::DP_SHIFT_STEP) |->
		idx_q < count_q)
		else $error("scan index ran past the live words");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bdq_pkg::DP_PUSH_FRONT || cmd.op == bdq_pkg::DP_PUSH_BACK) |=>
		count_q == $past(count_q) + 1'b1)
		else $error("push did not grow the count");

endmodule

@@ src/bounded_deque_with_erase_core.sv @@
// Top level of the bounded deque with erase-by-value.
// Depends on bdq_pkg, bdq_ctrl and bdq_dp.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  request  | req_valid / req_stall | req: req_type, operand_value
//  response | rsp_valid / rsp_stall | rsp: result_value, status, entry_count
//
// One request at a time. After the accepting edge, pushes, full or empty
// failures and unknown codes pass through decode and done, pops through
// decode, pop and done, and an erase over n stored words through decode and search,
// then shift if the match is not the last word, then done, covering all n words
// whether it hits or misses: the scan reads words up to the match and the shift
// moves the rest, one word a cycle. The next request is accepted in the cycle after the response is loaded.
// Reset clears the front index, the count and the handshake state at once;
// the word store is not cleared and only live words are ever read.
// A stalled response holds in its register; the next request is accepted and
// worked on, and its result waits until the output register is free.
module bounded_deque_with_erase_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bdq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bdq_pkg::rsp_t rsp
);

	// commands from the controller, flags back from the datapath
	bdq_pkg::dp_cmd_t  cmd;
	bdq_pkg::dp_stat_t stat;

	// sequence the request: decode, read, scan, shift, then present the result
	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// hold the words, the front index and count, and the response register
	bdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
